// ===== src/adaptive_input_delay_estimator_defines.svh =====
// Assertion macros used by the delay estimator datapath
`ifndef ADAPTIVE_INPUT_DELAY_ESTIMATOR_DEFINES_SVH
`define ADAPTIVE_INPUT_DELAY_ESTIMATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define AIDE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define AIDE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/aide_pkg.sv =====
// Shared types and constants for the adaptive input delay estimator
`default_nettype none

package aide_pkg;

    localparam int SEQ_W   = 32;
    localparam int TOTAL_W = 15;
    localparam int SUM_W   = 18;
    localparam int DELAY_W = 8;

    localparam logic [TOTAL_W-1:0] SAMPLE_LIMIT = 15'd20000;
    localparam logic [SEQ_W-1:0]   MAX_DISTANCE = 32'd9;
    localparam logic signed [DELAY_W-1:0] DELAY_CAP = 8'sd10;

    // restoring divider: one quotient bit per cycle
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } aide_state_t;

    typedef struct packed {
        logic take;      // capture request, update counters, load divider
        logic div_step;  // one divider iteration
        logic emit;      // write delay and load result register
    } aide_cmd_t;

    typedef struct packed {
        logic need_div;  // request on the input is a sample inside the window
        logic div_last;  // final divider iteration this cycle
        logic out_free;  // result register can take a new value
    } aide_stat_t;

endpackage

`default_nettype wire

// ===== src/aide_ctrl.sv =====
// Sequencer for the delay estimator: accept, divide, emit
`default_nettype none

module aide_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire aide_pkg::aide_stat_t stat,
    output aide_pkg::aide_cmd_t   cmd
);

    aide_pkg::aide_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= aide_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            aide_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = stat.need_div ? aide_pkg::ST_DIV : aide_pkg::ST_FIN;
                end
            end
            aide_pkg::ST_DIV: begin
                if (stat.div_last) begin
                    state_next = aide_pkg::ST_FIN;
                end
            end
            aide_pkg::ST_FIN: begin
                if (stat.out_free) begin
                    state_next = aide_pkg::ST_IDLE;
                end
            end
            default: state_next = aide_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_ready  = 1'b0;
        unique case (state_reg)
            aide_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
            end
            aide_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            aide_pkg::ST_FIN: begin
                cmd.emit = stat.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/aide_dp.sv =====
// Datapath: lag statistics, serial divider, delay and result registers
`default_nettype none
`include "adaptive_input_delay_estimator_defines.svh"

module aide_dp (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_wr_en,
    input  wire logic signed [aide_pkg::DELAY_W-1:0]  cfg_wr_data,
    input  wire logic        [aide_pkg::SEQ_W-1:0]    s_sequence_number,
    input  wire logic        [aide_pkg::SEQ_W-1:0]    s_acked_mark,
    input  wire aide_pkg::aide_cmd_t                  cmd,
    output aide_pkg::aide_stat_t                      stat,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [aide_pkg::DELAY_W-1:0]       m_delay_value,
    output logic                                      m_delay_updated
);

    logic signed [aide_pkg::DELAY_W-1:0] base_delay_reg;
    logic        [aide_pkg::TOTAL_W-1:0] sample_total_reg;
    logic        [aide_pkg::SUM_W-1:0]   lag_sum_reg;
    logic signed [aide_pkg::DELAY_W-1:0] delay_reg;
    logic        [aide_pkg::SUM_W-1:0]   quo_reg;
    logic        [aide_pkg::TOTAL_W-1:0] divisor_reg;
    logic        [aide_pkg::TOTAL_W-1:0] rem_reg;
    logic        [aide_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                                upd_reg;
    logic                                m_valid_reg;
    logic signed [aide_pkg::DELAY_W-1:0] m_delay_value_reg;
    logic                                m_delay_updated_reg;

    logic [aide_pkg::SEQ_W-1:0]   lag_dist;
    logic                         is_sample;
    logic [aide_pkg::TOTAL_W-1:0] total_inc;
    logic [aide_pkg::SUM_W-1:0]   sum_inc;
    logic                         in_window;
    logic                         past_limit;

    logic [aide_pkg::TOTAL_W:0]   trial;
    logic                         trial_ge;

    logic signed [aide_pkg::DELAY_W-1:0] cand;
    logic signed [aide_pkg::DELAY_W-1:0] chosen;
    logic signed [aide_pkg::DELAY_W-1:0] capped;
    logic signed [aide_pkg::DELAY_W-1:0] delay_next;

    // sample classification on the incoming request
    always_comb begin
        lag_dist   = s_sequence_number - s_acked_mark;
        is_sample  = (lag_dist <= aide_pkg::MAX_DISTANCE) && (s_sequence_number != '0);
        total_inc  = sample_total_reg + aide_pkg::TOTAL_W'(1);
        sum_inc    = lag_sum_reg + aide_pkg::SUM_W'(lag_dist[3:0]);
        in_window  = (total_inc != '0) && (total_inc < aide_pkg::SAMPLE_LIMIT);
        past_limit = total_inc > aide_pkg::SAMPLE_LIMIT;
    end

    // restoring division step
    always_comb begin
        trial    = {rem_reg, quo_reg[aide_pkg::SUM_W-1]};
        trial_ge = trial >= {1'b0, divisor_reg};
    end

    // delay recompute from truncated mean; only the low byte of the mean matters
    always_comb begin
        cand       = base_delay_reg + $signed(quo_reg[aide_pkg::DELAY_W-1:0]);
        chosen     = (cand > base_delay_reg) ? cand : base_delay_reg;
        capped     = (chosen > aide_pkg::DELAY_CAP) ? aide_pkg::DELAY_CAP : chosen;
        delay_next = upd_reg ? capped : delay_reg;
    end

    always_comb begin
        stat.need_div = is_sample && in_window;
        stat.div_last = cnt_reg == aide_pkg::DIV_CNT_W'(aide_pkg::DIV_STEPS - 1);
        stat.out_free = !m_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_delay_reg   <= '0;
            sample_total_reg <= '0;
            lag_sum_reg      <= '0;
            delay_reg        <= '0;
            upd_reg          <= 1'b0;
            cnt_reg          <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                base_delay_reg <= cfg_wr_data;
            end
            if (cmd.take) begin
                upd_reg <= is_sample && in_window;
                cnt_reg <= '0;
                if (is_sample) begin
                    if (past_limit) begin
                        sample_total_reg <= '0;
                        lag_sum_reg      <= '0;
                    end else begin
                        sample_total_reg <= total_inc;
                        lag_sum_reg      <= sum_inc;
                    end
                end
            end
            if (cmd.div_step) begin
                cnt_reg <= cnt_reg + aide_pkg::DIV_CNT_W'(1);
            end
            if (cmd.emit) begin
                delay_reg <= delay_next;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // divider and result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            quo_reg     <= sum_inc;
            divisor_reg <= total_inc;
            rem_reg     <= '0;
        end else if (cmd.div_step) begin
            quo_reg <= {quo_reg[aide_pkg::SUM_W-2:0], trial_ge};
            rem_reg <= trial_ge ? aide_pkg::TOTAL_W'(trial - {1'b0, divisor_reg})
                                : trial[aide_pkg::TOTAL_W-1:0];
        end
        if (cmd.emit) begin
            m_delay_value_reg   <= delay_next;
            m_delay_updated_reg <= upd_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_delay_value   = m_delay_value_reg;
    assign m_delay_updated = m_delay_updated_reg;

    `AIDE_ASSERT_NOW(a_total_bounded, aclk, aresetn, 1'b1,
        sample_total_reg <= aide_pkg::SAMPLE_LIMIT, "sample count above window limit")
    `AIDE_ASSERT_NOW(a_rem_below_div, aclk, aresetn, cmd.div_step,
        rem_reg < divisor_reg, "divider remainder not below divisor")
    `AIDE_ASSERT_NEXT(a_delay_capped, aclk, aresetn, cmd.emit,
        $signed(delay_reg) <= aide_pkg::DELAY_CAP, "delay above cap after update")

endmodule

`default_nettype wire

// ===== src/adaptive_input_delay_estimator.sv =====
// Top level of the adaptive input delay estimator
//
//  channel  direction  handshake          payload
//  s_       in         s_valid/s_ready    s_sequence_number, s_acked_mark
//  m_       out        m_valid/m_ready    m_delay_value, m_delay_updated
//  cfg_     in         cfg_wr_en          cfg_wr_data (base delay)
//
// A sample request inside the window holds the block through the capture
// state, the bit-serial restoring divider and the write state, where its
// result is registered; any other request skips the divider.
// aresetn is synchronous, active low; it clears the counters, delay and base.
// A result waiting on m_ready does not block the next request; a second
// finished result waits in the write state until the output register frees.
`default_nettype none

module adaptive_input_delay_estimator (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic signed [aide_pkg::DELAY_W-1:0] cfg_wr_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic        [aide_pkg::SEQ_W-1:0]   s_sequence_number,
    input  wire logic        [aide_pkg::SEQ_W-1:0]   s_acked_mark,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [aide_pkg::DELAY_W-1:0]      m_delay_value,
    output logic                                     m_delay_updated
);

    aide_pkg::aide_cmd_t  cmd;
    aide_pkg::aide_stat_t stat;

    aide_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    aide_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_sequence_number (s_sequence_number),
        .s_acked_mark      (s_acked_mark),
        .cmd               (cmd),
        .stat              (stat),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_delay_value     (m_delay_value),
        .m_delay_updated   (m_delay_updated)
    );

endmodule

`default_nettype wire
